// ===== design/ckha_pkg.sv =====
// ----------------------------------------------------------------------------
// ckha_pkg
// shared types, opcodes and the crc32c word update for the key hash block
// ----------------------------------------------------------------------------
package ckha_pkg;

    localparam int unsigned HashW  = 32;
    localparam int unsigned WordW  = 64;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned NBytes = WordW / ByteW;
    localparam int unsigned CountW = $clog2(NBytes);

    localparam logic [HashW-1:0] CrcPoly = 32'h82F6_3B78;

    typedef enum logic [1:0] {
        OP_WORD = 2'd0,
        OP_WIDE = 2'd1,
        OP_TAIL = 2'd2,
        OP_RSVD = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic [WordW-1:0]   data_low;
        logic [WordW-1:0]   data_high;
        logic [CountW-1:0]  tail_count;
        logic               restart;
        logic [HashW-1:0]   seed;
    } t_item;

    // reflected crc32c over one 64-bit word, lsb first, no inversion
    function automatic logic [HashW-1:0] crc32c_word(
        input logic [HashW-1:0] crc,
        input logic [WordW-1:0] word
    );
        logic [HashW-1:0] c;
        logic             fb;
        c = crc;
        for (int b = 0; b < WordW; b++) begin
            fb = c[0] ^ word[b];
            c  = (c >> 1) ^ (fb ? CrcPoly : '0);
        end
        return c;
    endfunction

endpackage

// ===== design/ckha_tail_pack.sv =====
// ----------------------------------------------------------------------------
// ckha_tail_pack
// packs a 1 to 7 byte string tail into one word, first byte most significant
// ----------------------------------------------------------------------------
module ckha_tail_pack (
    input  logic [ckha_pkg::WordW-1:0]  i_bytes,
    input  logic [ckha_pkg::CountW-1:0] i_count,
    output logic [ckha_pkg::WordW-1:0]  o_packed
);

    always_comb begin
        logic [ckha_pkg::CountW-1:0] src;
        o_packed = '0;
        for (int j = 0; j < ckha_pkg::NBytes; j++) begin
            src = i_count - ckha_pkg::CountW'(j) - ckha_pkg::CountW'(1);
            if (ckha_pkg::CountW'(j) < i_count) begin
                o_packed[j*ckha_pkg::ByteW +: ckha_pkg::ByteW] =
                    i_bytes[src*ckha_pkg::ByteW +: ckha_pkg::ByteW];
            end
        end
    end

endmodule

// ===== design/ckha_crc_core.sv =====
// ----------------------------------------------------------------------------
// ckha_crc_core
// start value select and crc32c update of one item, pure xor network
// ----------------------------------------------------------------------------
module ckha_crc_core (
    input  ckha_pkg::t_item            i_item,
    input  logic [ckha_pkg::HashW-1:0] i_run_hash,
    output logic [ckha_pkg::HashW-1:0] o_hash
);

    logic [ckha_pkg::HashW-1:0] start;
    logic [ckha_pkg::HashW-1:0] mid;
    logic [ckha_pkg::WordW-1:0] packed_tail;
    logic [ckha_pkg::WordW-1:0] last_word;
    logic [ckha_pkg::HashW-1:0] last_hash;

    ckha_tail_pack u_tail_pack (
        .i_bytes  (i_item.data_low),
        .i_count  (i_item.tail_count),
        .o_packed (packed_tail)
    );

    assign start     = i_item.restart ? i_item.seed : i_run_hash;
    // high half of a wide value goes first
    assign mid       = (i_item.opcode == ckha_pkg::OP_WIDE)
                     ? ckha_pkg::crc32c_word(start, i_item.data_high) : start;
    assign last_word = (i_item.opcode == ckha_pkg::OP_TAIL) ? packed_tail : i_item.data_low;
    assign last_hash = ckha_pkg::crc32c_word(mid, last_word);

    always_comb begin
        unique case (i_item.opcode) inside
            ckha_pkg::OP_WORD,
            ckha_pkg::OP_WIDE: o_hash = last_hash;
            ckha_pkg::OP_TAIL: o_hash = (i_item.tail_count != '0) ? last_hash : start;
            default:           o_hash = start;
        endcase
    end

endmodule

// ===== design/crc32c_key_hash_accumulator.sv =====
// ----------------------------------------------------------------------------
// crc32c_key_hash_accumulator
// chained crc32c hash of key words, 128-bit values and string tails
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  in      | i_in_valid   | o_in_stall   | i_opcode i_data_low i_data_high
//          |              |              | i_tail_count i_restart i_seed
//  out     | o_out_valid  | i_out_stall  | o_hash_value
//
//  one beat per cycle in and out while the output is not stalled; a taken beat
//  loads the input register, then moves into the result register to be offered
//  the running hash updates as an item moves into the result register, so the
//  next item in the input register sees it with no bubble
//  reset clears both valid flags and the running hash to zero
//  o_in_stall rises only when both registers hold beats and the output stalls
// ----------------------------------------------------------------------------
module crc32c_key_hash_accumulator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [ckha_pkg::WordW-1:0]    i_data_low,
    input  logic [ckha_pkg::WordW-1:0]    i_data_high,
    input  logic [ckha_pkg::CountW-1:0]   i_tail_count,
    input  logic                          i_restart,
    input  logic [ckha_pkg::HashW-1:0]    i_seed,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ckha_pkg::HashW-1:0]    o_hash_value
);

    ckha_pkg::t_item            r_item;
    logic                       r_in_vld;
    logic                       r_out_vld;
    logic [ckha_pkg::HashW-1:0] r_out_hash;
    logic [ckha_pkg::HashW-1:0] r_run_hash;

    logic                       n_in_vld;
    logic                       n_out_vld;
    logic [ckha_pkg::HashW-1:0] n_hash;
    logic                       out_free;
    logic                       in_free;
    logic                       advance;
    logic                       take;

    assign out_free = !r_out_vld || !i_out_stall;
    assign advance  = r_in_vld && out_free;
    assign in_free  = !r_in_vld || out_free;
    assign take     = i_in_valid && in_free;

    assign n_in_vld  = take || (r_in_vld && !out_free);
    assign n_out_vld = advance || (r_out_vld && i_out_stall);

    ckha_crc_core u_crc_core (
        .i_item     (r_item),
        .i_run_hash (r_run_hash),
        .o_hash     (n_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_run_hash <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (advance) begin
                r_run_hash <= n_hash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.opcode     <= ckha_pkg::t_opcode'(i_opcode);
            r_item.data_low   <= i_data_low;
            r_item.data_high  <= i_data_high;
            r_item.tail_count <= i_tail_count;
            r_item.restart    <= i_restart;
            r_item.seed       <= i_seed;
        end
        if (advance) begin
            r_out_hash <= n_hash;
        end
    end

    assign o_in_stall   = !in_free;
    assign o_out_valid  = r_out_vld;
    assign o_hash_value = r_out_hash;

endmodule

// ===== design/ckha_checker.sv =====
// ----------------------------------------------------------------------------
// ckha_checker
// port level checks on the key hash block, bound to the top level
// ----------------------------------------------------------------------------
module ckha_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [ckha_pkg::HashW-1:0]    o_hash_value
);

    // a held result must stay offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_hash_value))
        else $error("result changed while stalled");

    // input only backs up when the result side is full and stalled
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("beats present after reset");

endmodule

bind crc32c_key_hash_accumulator ckha_checker u_ckha_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hash_value (o_hash_value)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the crc32c key hash accumulator: directed words,
// 128-bit values, string tails and pass-through items, then random key chains
// under several idle and stall mixes, each hash compared in order
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    logic                            i_clk        = 1'b0;
    logic                            i_rst_n      = 1'b0;
    logic                            i_in_valid   = 1'b0;
    logic                            o_in_stall;
    logic [1:0]                      i_opcode     = ckha_pkg::OP_WORD;
    logic [ckha_pkg::WordW-1:0]      i_data_low   = '0;
    logic [ckha_pkg::WordW-1:0]      i_data_high  = '0;
    logic [ckha_pkg::CountW-1:0]     i_tail_count = '0;
    logic                            i_restart    = 1'b0;
    logic [ckha_pkg::HashW-1:0]      i_seed       = '0;
    logic                            o_out_valid;
    logic                            i_out_stall  = 1'b0;
    logic [ckha_pkg::HashW-1:0]      o_hash_value;

    logic [ckha_pkg::HashW-1:0]      running_key_hash = '0;
    logic [ckha_pkg::HashW-1:0]      hash_expect_q[$];
    int                              sender_idle_pct  = 0;
    int                              recv_stall_pct   = 0;
    int                              errors           = 0;
    int                              hashes_checked   = 0;
    int                              beats_by_op[4]   = '{0, 0, 0, 0};

    crc32c_key_hash_accumulator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_data_low   (i_data_low),
        .i_data_high  (i_data_high),
        .i_tail_count (i_tail_count),
        .i_restart    (i_restart),
        .i_seed       (i_seed),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bytewise reflected crc32c, least significant byte first
    function automatic logic [ckha_pkg::HashW-1:0] crc_fold_word(
        input logic [ckha_pkg::HashW-1:0] crc,
        input logic [ckha_pkg::WordW-1:0] word
    );
        logic [ckha_pkg::HashW-1:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            c ^= {24'd0, word[8*k +: 8]};
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ ckha_pkg::CrcPoly) : (c >> 1);
            end
        end
        return c;
    endfunction

    // first tail byte ends up most significant
    function automatic logic [ckha_pkg::WordW-1:0] pack_tail_bytes(
        input logic [ckha_pkg::WordW-1:0]  bytes,
        input logic [ckha_pkg::CountW-1:0] count
    );
        logic [ckha_pkg::WordW-1:0] p;
        p = '0;
        for (int i = 0; i < count; i++) begin
            p = {p[ckha_pkg::WordW-9:0], bytes[8*i +: 8]};
        end
        return p;
    endfunction

    function automatic logic [ckha_pkg::HashW-1:0] next_key_hash(
        input ckha_pkg::t_item            it,
        input logic [ckha_pkg::HashW-1:0] cur
    );
        logic [ckha_pkg::HashW-1:0] h;
        h = it.restart ? it.seed : cur;
        case (it.opcode)
            ckha_pkg::OP_WORD: h = crc_fold_word(h, it.data_low);
            ckha_pkg::OP_WIDE: h = crc_fold_word(crc_fold_word(h, it.data_high), it.data_low);
            ckha_pkg::OP_TAIL: begin
                if (it.tail_count != 0) begin
                    h = crc_fold_word(h, pack_tail_bytes(it.data_low, it.tail_count));
                end
            end
            default: ;
        endcase
        return h;
    endfunction

    function automatic ckha_pkg::t_item make_item(
        input ckha_pkg::t_opcode           op,
        input logic [ckha_pkg::WordW-1:0]  lo,
        input logic [ckha_pkg::WordW-1:0]  hi,
        input logic [ckha_pkg::CountW-1:0] cnt,
        input logic                        rst,
        input logic [ckha_pkg::HashW-1:0]  seed
    );
        ckha_pkg::t_item it;
        it.opcode     = op;
        it.data_low   = lo;
        it.data_high  = hi;
        it.tail_count = cnt;
        it.restart    = rst;
        it.seed       = seed;
        return it;
    endfunction

    function automatic logic [ckha_pkg::WordW-1:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_beat(input ckha_pkg::t_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= it.opcode;
        i_data_low   <= it.data_low;
        i_data_high  <= it.data_high;
        i_tail_count <= it.tail_count;
        i_restart    <= it.restart;
        i_seed       <= it.seed;
        do @(posedge i_clk); while (o_in_stall);
        running_key_hash = next_key_hash(it, running_key_hash);
        hash_expect_q.push_back(running_key_hash);
        beats_by_op[it.opcode]++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (hash_expect_q.size() == 0) begin
                $display("%0t: unexpected hash beat, actual %08h", $time, o_hash_value);
                errors++;
            end else begin
                if (o_hash_value !== hash_expect_q[0]) begin
                    $display("%0t: hash mismatch, expected %08h actual %08h",
                             $time, hash_expect_q[0], o_hash_value);
                    errors++;
                end
                void'(hash_expect_q.pop_front());
                hashes_checked++;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic test_word_extremes();
        send_beat(make_item(ckha_pkg::OP_WORD, '0, '0, '0, 1'b1, '0));
        send_beat(make_item(ckha_pkg::OP_WORD, '1, '0, '0, 1'b0, '0));
        send_beat(make_item(ckha_pkg::OP_WORD, 64'h0123_4567_89AB_CDEF, '0, '0, 1'b1, '1));
        // fields that a word ignores
        send_beat(make_item(ckha_pkg::OP_WORD, 64'h8000_0000_0000_0001, '1, '1, 1'b0, '1));
    endtask

    task automatic test_wide_values();
        send_beat(make_item(ckha_pkg::OP_WIDE, '0, '1, '0, 1'b0, '0));
        send_beat(make_item(ckha_pkg::OP_WIDE, '1, '0, '1, 1'b1, 32'hDEAD_BEEF));
        send_beat(make_item(ckha_pkg::OP_WIDE, '1, '1, '0, 1'b0, '0));
    endtask

    task automatic test_string_tails();
        // empty tail with restart gives back the seed
        send_beat(make_item(ckha_pkg::OP_TAIL, 64'h8877_6655_4433_2211, '1, 3'd0, 1'b1,
                            32'h1234_5678));
        for (int n = 1; n < 8; n++) begin
            send_beat(make_item(ckha_pkg::OP_TAIL, 64'h8877_6655_4433_2211, '1,
                                n[ckha_pkg::CountW-1:0], 1'b0, '1));
        end
        send_beat(make_item(ckha_pkg::OP_TAIL, '1, '0, 3'd0, 1'b0, '0));
        // bytes above the count must not matter
        send_beat(make_item(ckha_pkg::OP_TAIL, 64'hFFFF_FFFF_FF00_0000, '0, 3'd3, 1'b1, '0));
    endtask

    task automatic test_reserved_and_restart();
        send_beat(make_item(ckha_pkg::OP_RSVD, '1, '1, '1, 1'b0, '1));
        send_beat(make_item(ckha_pkg::OP_RSVD, '1, '1, '1, 1'b1, 32'hA5A5_5A5A));
        send_beat(make_item(ckha_pkg::OP_WORD, '0, '0, '0, 1'b1, '1));
    endtask

    task automatic test_random_keys(input int beats, input int sidle, input int rstall);
        ckha_pkg::t_item   it;
        int                left;
        int                r;
        ckha_pkg::t_opcode op;
        sender_idle_pct = sidle;
        recv_stall_pct  = rstall;
        left = 0;
        for (int i = 0; i < beats; i++) begin
            r = $urandom_range(99);
            op = (r < 50) ? ckha_pkg::OP_WORD :
                 (r < 75) ? ckha_pkg::OP_WIDE :
                 (r < 95) ? ckha_pkg::OP_TAIL : ckha_pkg::OP_RSVD;
            it = make_item(op, rand_word(), rand_word(), 3'($urandom_range(7)),
                           1'b0, $urandom);
            if (left == 0) begin
                it.restart = 1'b1;
                left = $urandom_range(12, 1);
            end else if ($urandom_range(15) == 0) begin
                it.restart = 1'b1;
            end
            if ($urandom_range(9) == 0) begin
                it.seed = $urandom_range(1) ? '1 : '0;
            end
            left--;
            send_beat(it);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_word_extremes();
        test_wide_values();
        test_string_tails();
        test_reserved_and_restart();
        test_random_keys(500, 0, 0);
        test_random_keys(500, 63, 0);
        test_random_keys(500, 0, 63);
        test_random_keys(500, 6, 6);
        i_in_valid <= 1'b0;
        while (hash_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("checked %0d hashes: %0d word, %0d wide, %0d tail, %0d pass-through beats",
                 hashes_checked, beats_by_op[ckha_pkg::OP_WORD],
                 beats_by_op[ckha_pkg::OP_WIDE], beats_by_op[ckha_pkg::OP_TAIL],
                 beats_by_op[ckha_pkg::OP_RSVD]);
        if (errors == 0) begin
            $display("crc32c_key_hash_accumulator verification clean");
        end else begin
            $display("crc32c_key_hash_accumulator verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("%0t: timeout with %0d hashes outstanding", $time, hash_expect_q.size());
        $display("crc32c_key_hash_accumulator verification failed");
        $finish;
    end

endmodule
